// ----- hdl/dls_pkg.sv -----
package dls_pkg;

	localparam int MAX_VERTICES_DEF = 32;
	localparam int ID_W             = 32;
	localparam int STATUS_W         = 3;
	localparam int LEVEL_W          = 5;

	typedef enum logic [1:0] {
		OP_ADD_VERTEX = 2'd0,
		OP_ADD_DEP    = 2'd1,
		OP_PLAN       = 2'd2,
		OP_NONE       = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_DUP     = 3'd1,
		ST_FULL    = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_CYCLE   = 3'd4,
		ST_EMPTY   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_DECIDE,
		S_RCH_PICK,
		S_RCH_OR,
		S_LINK_RD,
		S_LINK_WR,
		S_LVL,
		S_SEL,
		S_EMIT
	} state_t;

endpackage

// ----- hdl/dependency_level_scheduler.sv -----
// every command first looks its ids up in the id memory,
// one id memory entry per cycle; add vertex then replies from the decide step
// add dependency: walks every vertex reachable from the child, then reads and writes the parent row to commit
// plan: a dependency row sweep per level plus an id sweep per emitted vertex
// one command in flight at a time; results come out one beat per strobe, no stall
// reset: asynchronous, clears the vertex count and control; memories are not cleared
module dependency_level_scheduler #(
	parameter int MAX_VERTICES = dls_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic [dls_pkg::ID_W-1:0]      first_id,
	input  logic [dls_pkg::ID_W-1:0]      second_id,
	output logic                          result_strobe,
	output logic [dls_pkg::STATUS_W-1:0]  status,
	output logic [dls_pkg::LEVEL_W-1:0]   level,
	output logic [dls_pkg::ID_W-1:0]      vertex_id,
	output logic                          last_in_level,
	output logic                          last
);
	import dls_pkg::*;

	localparam int N  = MAX_VERTICES;
	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);

	// command register
	state_t             state_q, state_d;
	opcode_t            op_q;
	logic [ID_W-1:0]    a_q, b_q;
	logic [CW-1:0]      count_q;

	// sweep counter and the read stage behind it
	logic [CW-1:0]      cnt_q;
	logic               vld_s1;
	logic [IW-1:0]      idx_s1;
	logic               scan_st;
	logic               scan_more;

	// lookup hits
	logic               p_hit_q, c_hit_q;
	logic [IW-1:0]      p_idx_q, c_idx_q;

	// reachability worklist
	logic [N-1:0]       reach_q, visit_q, pend;
	logic [IW-1:0]      pick_idx;
	logic               pick_found;

	// plan walk
	logic [N-1:0]       done_q, blocked_q, ready_q, left_q, nmask, ready_w, best_bit, left_nx;
	logic [IW-1:0]      best_idx_q;
	logic [ID_W-1:0]    best_id_q;
	logic               best_hit_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [CW-1:0]      k_q;
	logic               lvl_end, plan_end;
	logic               strobe_d;

	// memories: ids and dependency rows, registered read
	logic [ID_W-1:0]    tbl_mem [N];
	logic [N-1:0]       edg_mem [N];
	logic               tbl_we, edg_we;
	logic [IW-1:0]      tbl_waddr, tbl_raddr, edg_waddr, edg_raddr;
	logic [ID_W-1:0]    tbl_wdata, tbl_rdata_q;
	logic [N-1:0]       edg_wdata, edg_rdata_q;

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		tbl_rdata_q <= tbl_mem[tbl_raddr];
	end

	always_ff @(posedge clk) begin
		if (edg_we) begin
			edg_mem[edg_waddr] <= edg_wdata;
		end
		edg_rdata_q <= edg_mem[edg_raddr];
	end

	// next vertex of the worklist to expand
	assign pend = reach_q & ~visit_q;

	dls_lowbit #(.W(N)) u_pick (
		.vec   (pend),
		.idx   (pick_idx),
		.found (pick_found)
	);

	// slots in use
	always_comb begin
		for (int i = 0; i < N; i++) begin
			nmask[i] = (CW'(i) < count_q);
		end
	end

	assign ready_w   = ~done_q & ~blocked_q & nmask;
	assign best_bit  = {{(N-1){1'b0}}, 1'b1} << best_idx_q;
	assign left_nx   = left_q & ~best_bit;
	assign lvl_end   = (left_nx == '0);
	assign plan_end  = lvl_end && ((k_q + CW'(1)) == count_q);
	assign scan_st   = (state_q == S_FIND) || (state_q == S_LVL) || (state_q == S_SEL);
	assign scan_more = (cnt_q < count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_FIND;
			end
			S_FIND: begin
				if (!scan_more && !vld_s1) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				unique case (op_q)
					OP_ADD_DEP: state_d = (p_hit_q && c_hit_q) ? S_RCH_PICK : S_IDLE;
					OP_PLAN:    state_d = (count_q != '0) ? S_LVL : S_IDLE;
					OP_ADD_VERTEX, OP_NONE: state_d = S_IDLE;
					default:    state_d = S_IDLE;
				endcase
			end
			S_RCH_PICK: begin
				if (pick_found) state_d = S_RCH_OR;
				else state_d = reach_q[p_idx_q] ? S_IDLE : S_LINK_RD;
			end
			S_RCH_OR:  state_d = S_RCH_PICK;
			S_LINK_RD: state_d = S_LINK_WR;
			S_LINK_WR: state_d = S_IDLE;
			S_LVL: begin
				if (!scan_more && !vld_s1) state_d = S_SEL;
			end
			S_SEL: begin
				if (!scan_more && !vld_s1) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (plan_end) state_d = S_IDLE;
				else if (lvl_end) state_d = S_LVL;
				else state_d = S_SEL;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// reply strobe for the next cycle
	always_comb begin
		strobe_d = 1'b0;
		unique case (state_q)
			S_DECIDE: begin
				strobe_d = (op_q != OP_ADD_DEP && !(op_q == OP_PLAN && count_q != '0)) ||
				           (op_q == OP_ADD_DEP && !(p_hit_q && c_hit_q));
			end
			S_RCH_PICK: strobe_d = !pick_found && reach_q[p_idx_q];
			S_LINK_WR, S_EMIT: strobe_d = 1'b1;
			S_IDLE, S_FIND, S_RCH_OR, S_LINK_RD, S_LVL, S_SEL: begin
			end
			default: begin
			end
		endcase
	end

	// memory control
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = count_q[IW-1:0];
		tbl_wdata = a_q;
		tbl_raddr = cnt_q[IW-1:0];
		edg_we    = 1'b0;
		edg_waddr = count_q[IW-1:0];
		edg_wdata = '0;
		edg_raddr = cnt_q[IW-1:0];
		unique case (state_q)
			S_DECIDE: begin
				// fresh vertex gets a cleared dependency row
				if (op_q == OP_ADD_VERTEX && !p_hit_q && count_q != CW'(N)) begin
					tbl_we = 1'b1;
					edg_we = 1'b1;
				end
			end
			S_RCH_PICK: edg_raddr = pick_idx;
			S_LINK_RD:  edg_raddr = p_idx_q;
			S_LINK_WR: begin
				edg_we    = 1'b1;
				edg_waddr = p_idx_q;
				edg_wdata = edg_rdata_q | ({{(N-1){1'b0}}, 1'b1} << c_idx_q);
			end
			S_IDLE, S_FIND, S_RCH_OR, S_LVL, S_SEL, S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			state_q <= state_d;
			result_strobe <= strobe_d;

			// sweep issue: one entry per cycle
			if (scan_st && scan_more) begin
				vld_s1 <= 1'b1;
				cnt_q  <= cnt_q + CW'(1);
			end else begin
				vld_s1 <= 1'b0;
			end

			if (state_q == S_DECIDE && op_q == OP_ADD_VERTEX &&
			    !p_hit_q && count_q != CW'(N)) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == S_DECIDE || state_q == S_EMIT) begin
				cnt_q <= '0;
			end
			if (state_q == S_LVL && !scan_more && !vld_s1) begin
				cnt_q <= '0;
			end
			if (state_q == S_IDLE) begin
				cnt_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (scan_st && scan_more) idx_s1 <= cnt_q[IW-1:0];

		unique case (state_q)
			S_IDLE: begin
				op_q    <= opcode_t'(opcode);
				a_q     <= first_id;
				b_q     <= second_id;
				p_hit_q <= 1'b0;
				c_hit_q <= 1'b0;
			end
			S_FIND: begin
				if (vld_s1 && !p_hit_q && tbl_rdata_q == a_q) begin
					p_hit_q <= 1'b1;
					p_idx_q <= idx_s1;
				end
				if (vld_s1 && !c_hit_q && tbl_rdata_q == b_q) begin
					c_hit_q <= 1'b1;
					c_idx_q <= idx_s1;
				end
			end
			S_DECIDE: begin
				level         <= '0;
				vertex_id     <= '0;
				last_in_level <= 1'b0;
				last          <= 1'b1;
				unique case (op_q)
					OP_ADD_VERTEX: begin
						status <= p_hit_q ? ST_DUP :
						          ((count_q == CW'(N)) ? ST_FULL : ST_OK);
					end
					OP_ADD_DEP: begin
						status <= (p_hit_q && c_hit_q) ? ST_OK : ST_UNKNOWN;
					end
					OP_PLAN: begin
						status <= (count_q == '0) ? ST_EMPTY : ST_OK;
					end
					OP_NONE: begin
						status <= ST_OK;
					end
					default: begin
						status <= ST_OK;
					end
				endcase
				// seed walk state for the longer commands
				reach_q    <= {{(N-1){1'b0}}, 1'b1} << c_idx_q;
				visit_q    <= '0;
				done_q     <= '0;
				blocked_q  <= '0;
				lvl_q      <= '0;
				k_q        <= '0;
				best_hit_q <= 1'b0;
			end
			S_RCH_PICK: begin
				if (pick_found) begin
					visit_q <= visit_q | ({{(N-1){1'b0}}, 1'b1} << pick_idx);
				end else begin
					// child already reaches parent: edge would close a cycle
					status        <= ST_CYCLE;
					level         <= '0;
					vertex_id     <= '0;
					last_in_level <= 1'b0;
					last          <= 1'b1;
				end
			end
			S_RCH_OR: reach_q <= reach_q | edg_rdata_q;
			S_LINK_RD: begin
			end
			S_LINK_WR: begin
				status        <= ST_OK;
				level         <= '0;
				vertex_id     <= '0;
				last_in_level <= 1'b0;
				last          <= 1'b1;
			end
			S_LVL: begin
				// rows of unplaced vertices hold back their children
				if (vld_s1 && !done_q[idx_s1]) blocked_q <= blocked_q | edg_rdata_q;
				if (!scan_more && !vld_s1) begin
					ready_q    <= ready_w;
					left_q     <= ready_w;
					best_hit_q <= 1'b0;
				end
			end
			S_SEL: begin
				// smallest id among the level's remaining vertices
				if (vld_s1 && left_q[idx_s1] && (!best_hit_q || tbl_rdata_q < best_id_q)) begin
					best_hit_q <= 1'b1;
					best_idx_q <= idx_s1;
					best_id_q  <= tbl_rdata_q;
				end
			end
			S_EMIT: begin
				status        <= ST_OK;
				level         <= lvl_q;
				vertex_id     <= best_id_q;
				last_in_level <= lvl_end;
				last          <= plan_end;
				left_q        <= left_nx;
				k_q           <= k_q + CW'(1);
				best_hit_q    <= 1'b0;
				if (lvl_end) begin
					done_q    <= done_q | ready_q;
					lvl_q     <= lvl_q + LEVEL_W'(1);
					blocked_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// a command always leaves idle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");

	// the closing beat of a command coincides with return to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |-> !busy) else $error("busy after last beat");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |-> busy) else $error("idle inside plan");

	// error replies are single beats
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && status != ST_OK |-> last) else $error("error beat not last");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N)) else $error("vertex count overflow");

endmodule

// ----- hdl/dls_lowbit.sv -----
module dls_lowbit #(
	parameter int W = 32
) (
	input  logic [W-1:0]         vec,
	output logic [$clog2(W)-1:0] idx,
	output logic                 found
);
	// lowest set bit wins
	always_comb begin
		idx   = '0;
		found = 1'b0;
		for (int i = W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx   = ($clog2(W))'(i);
				found = 1'b1;
			end
		end
	end
endmodule
